// ===== hdl/i2cms_pkg.sv =====
// Package for the I2C master transaction sequencer.
// Holds item, result and state types, bus status codes and action codes.
// No dependencies.
package i2cms_pkg;

    localparam logic [7:0] ST_MASK   = 8'hF8;
    localparam logic [15:0] LOW_BYTE = 16'h00FF;
    localparam int BYTE_SHIFT        = 8;

    localparam logic [7:0] S_START        = 8'h08;
    localparam logic [7:0] S_REP_START    = 8'h10;
    localparam logic [7:0] S_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] S_MT_SLA_NACK  = 8'h20;
    localparam logic [7:0] S_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] S_ARB_LOST     = 8'h38;
    localparam logic [7:0] S_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] S_MR_SLA_NACK  = 8'h48;
    localparam logic [7:0] S_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] S_MR_DATA_NACK = 8'h58;

    localparam logic [3:0] RETRY_RESET = 4'd3;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_READ    = 2'd1,
        MODE_DONE    = 2'd2,
        MODE_TIMEOUT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        A_NONE    = 3'd0,
        A_START   = 3'd1,
        A_SEND    = 3'd2,
        A_RD_ACK  = 3'd3,
        A_RD_NACK = 3'd4,
        A_STOP    = 3'd5
    } action_t;

    typedef enum logic [3:0] {
        P_IDLE    = 4'd0,
        P_START   = 4'd1,
        P_SLA_W   = 4'd2,
        P_ADDR_H  = 4'd3,
        P_ADDR_L  = 4'd4,
        P_DATA_W  = 4'd5,
        P_RSTART  = 4'd6,
        P_SLA_R   = 4'd7,
        P_RD_ACK  = 4'd8,
        P_RD_NACK = 4'd9
    } phase_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  dev_address;
        logic [1:0]  addr_len;
        logic [15:0] reg_address;
        logic [7:0]  byte_count;
        logic [7:0]  status_code;
        logic [7:0]  rx_data;
        logic [7:0]  next_tx_byte;
    } item_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       success;
        logic       disable_bus;
    } result_t;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  attempts_used;
        logic [7:0]  bytes_done;
        logic [7:0]  saved_device;
        logic [1:0]  saved_addr_len;
        logic [15:0] saved_reg_address;
        logic [7:0]  saved_count;
        logic        is_read;
    } seq_state_t;

endpackage

// ===== hdl/i2cms_step.sv =====
// Next-state and result logic of the sequencer for one item.
// Purely combinational; uses i2cms_pkg.
module i2cms_step
    import i2cms_pkg::*;
(
    input  item_t      item,
    input  seq_state_t cur,
    input  logic [3:0] retry_limit,
    output seq_state_t nxt,
    output result_t    res
);

    logic [7:0] st;
    logic       do_restart;
    logic       do_fail;
    logic       do_ok;
    logic [3:0] att;
    logic [7:0] nb;

    always_comb
    begin
        st         = item.status_code & ST_MASK;
        nxt        = cur;
        res        = '0;
        res.action = A_NONE;
        do_restart = 1'b0;
        do_fail    = 1'b0;
        do_ok      = 1'b0;
        att        = cur.attempts_used;
        nb         = cur.bytes_done;

        if (item.mode == MODE_WRITE || item.mode == MODE_READ)
        begin
            nxt.saved_device      = item.dev_address;
            nxt.saved_addr_len    = item.addr_len;
            nxt.saved_reg_address = item.reg_address;
            nxt.saved_count       = item.byte_count;
            nxt.is_read           = (item.mode == MODE_READ);
            nxt.attempts_used     = '0;
            nxt.bytes_done        = '0;
            att                   = '0;
            if (item.mode == MODE_READ && item.byte_count == 8'd0)
                do_fail = 1'b1;
            else
                do_restart = 1'b1;
        end
        else if (cur.phase == P_IDLE)
        begin
            nxt = cur;
        end
        else if (item.mode == MODE_TIMEOUT)
        begin
            do_fail = 1'b1;
        end
        else
        begin
            unique case (cur.phase)
                P_START, P_RSTART:
                begin
                    if (st == S_ARB_LOST)
                        do_restart = 1'b1;
                    else if (st != S_START && st != S_REP_START)
                        do_fail = 1'b1;
                    else
                    begin
                        res.action = A_SEND;
                        if (cur.phase == P_START)
                        begin
                            res.tx_byte = cur.saved_device & 8'hFE;
                            nxt.phase   = P_SLA_W;
                        end
                        else
                        begin
                            res.tx_byte = cur.saved_device | 8'h01;
                            nxt.phase   = P_SLA_R;
                        end
                    end
                end
                P_SLA_W, P_ADDR_H, P_ADDR_L, P_DATA_W:
                begin
                    if (cur.phase == P_SLA_W
                        && (st == S_MT_SLA_NACK || st == S_ARB_LOST))
                        do_restart = 1'b1;
                    else if ((cur.phase == P_SLA_W && st != S_MT_SLA_ACK)
                             || (cur.phase != P_SLA_W && st != S_MT_DATA_ACK))
                        do_fail = 1'b1;
                    else if ((cur.phase == P_SLA_W && cur.saved_addr_len == 2'd2))
                    begin
                        res.action  = A_SEND;
                        res.tx_byte = cur.saved_reg_address[15:BYTE_SHIFT];
                        nxt.phase   = P_ADDR_H;
                    end
                    else if ((cur.phase == P_SLA_W && cur.saved_addr_len != 2'd0)
                             || cur.phase == P_ADDR_H)
                    begin
                        res.action  = A_SEND;
                        res.tx_byte = 8'(cur.saved_reg_address & LOW_BYTE);
                        nxt.phase   = P_ADDR_L;
                    end
                    else if (cur.is_read && cur.phase != P_DATA_W)
                    begin
                        res.action = A_START;
                        nxt.phase  = P_RSTART;
                    end
                    else if (cur.bytes_done < cur.saved_count)
                    begin
                        nxt.bytes_done = cur.bytes_done + 8'd1;
                        res.action     = A_SEND;
                        res.tx_byte    = item.next_tx_byte;
                        nxt.phase      = P_DATA_W;
                    end
                    else
                        do_ok = 1'b1;
                end
                P_SLA_R, P_RD_ACK:
                begin
                    if (cur.phase == P_SLA_R
                        && (st == S_MR_SLA_NACK || st == S_ARB_LOST))
                        do_restart = 1'b1;
                    else if ((cur.phase == P_SLA_R && st != S_MR_SLA_ACK)
                             || (cur.phase == P_RD_ACK && st != S_MR_DATA_ACK))
                        do_fail = 1'b1;
                    else
                    begin
                        if (cur.phase == P_SLA_R)
                            nb = '0;
                        else
                        begin
                            nb           = cur.bytes_done + 8'd1;
                            res.rx_valid = 1'b1;
                            res.rx_byte  = item.rx_data;
                        end
                        nxt.bytes_done = nb;
                        if ({1'b0, nb} + 9'd1 < {1'b0, cur.saved_count})
                        begin
                            res.action = A_RD_ACK;
                            nxt.phase  = P_RD_ACK;
                        end
                        else
                        begin
                            res.action = A_RD_NACK;
                            nxt.phase  = P_RD_NACK;
                        end
                    end
                end
                P_RD_NACK:
                begin
                    if (st != S_MR_DATA_NACK)
                        do_fail = 1'b1;
                    else
                    begin
                        res.rx_valid = 1'b1;
                        res.rx_byte  = item.rx_data;
                        do_ok        = 1'b1;
                    end
                end
                default:
                    nxt.phase = P_IDLE;
            endcase
        end

        if (do_restart)
        begin
            if (att >= retry_limit)
                do_fail = 1'b1;
            else
            begin
                nxt.attempts_used = att + 4'd1;
                nxt.bytes_done    = '0;
                res.action        = A_START;
                nxt.phase         = P_START;
            end
        end

        if (do_fail || do_ok)
        begin
            res.action      = A_STOP;
            res.done_res    = 1'b1;
            res.success     = do_ok && !do_fail;
            res.disable_bus = do_fail;
            nxt.phase       = P_IDLE;
        end
    end

endmodule

// ===== hdl/i2c_master_transaction_sequencer.sv =====
// Top level of the I2C master transaction sequencer: stream ports, input and
// result registers, sequencer state and the APB retry-limit register.
// Uses i2cms_pkg and i2cms_step.
//
//   channel   | handshake              | payload
//   ----------+------------------------+--------------------------------------
//   s_axis    | s_axis_tvalid/tready   | tuser: mode; tdata: request fields
//   m_axis    | m_axis_tvalid/tready   | tuser: action; tdata: result fields
//   apb       | psel/penable/pready    | paddr, pwrite, pwdata, prdata
//
// One result per item. An item is held in the input register, then is worked
// into the result register; one item per cycle sustained while m_axis_tready
// holds. While a result waits for m_axis_tready, the input side takes an item
// only if the input register is empty.
// Reset clears the sequencer to idle and sets retry_limit to 3.
module i2c_master_transaction_sequencer
    import i2cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // dev_address[7:0], addr_len[9:8], reg_address[25:10], byte_count[33:26],
    // status_code[41:34], rx_data[49:42], next_tx_byte[57:50], zero fill
    input  logic [63:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_byte[7:0], rx_valid[8], rx_byte[16:9], done_res[17], success[18],
    // disable_bus[19], zero fill
    output logic [23:0] m_axis_tdata,
    // action[2:0]
    output logic [2:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       in_vld_reg;
    item_t      in_item_reg;
    logic       out_vld_reg;
    result_t    out_res_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    res_next;
    logic [3:0] retry_reg;
    logic       advance;
    item_t      in_item;

    assign in_item.mode         = mode_t'(s_axis_tuser);
    assign in_item.dev_address  = s_axis_tdata[7:0];
    assign in_item.addr_len     = s_axis_tdata[9:8];
    assign in_item.reg_address  = s_axis_tdata[25:10];
    assign in_item.byte_count   = s_axis_tdata[33:26];
    assign in_item.status_code  = s_axis_tdata[41:34];
    assign in_item.rx_data      = s_axis_tdata[49:42];
    assign in_item.next_tx_byte = s_axis_tdata[57:50];

    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;

    i2cms_step u_step
    (
        .item        (in_item_reg),
        .cur         (state_reg),
        .retry_limit (retry_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
            retry_reg   <= RETRY_RESET;
        end
        else
        begin
            if (s_axis_tready)
                in_vld_reg <= s_axis_tvalid;
            if (advance)
            begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end
            else if (m_axis_tready)
                out_vld_reg <= 1'b0;
            if (psel && penable && pwrite && pready && !paddr[2])
                retry_reg <= pwdata[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_item_reg <= in_item;
        if (advance)
            out_res_reg <= res_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_res_reg.action;
    assign m_axis_tdata  = {4'b0, out_res_reg.disable_bus, out_res_reg.success,
                            out_res_reg.done_res, out_res_reg.rx_byte,
                            out_res_reg.rx_valid, out_res_reg.tx_byte};

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {28'd0, retry_reg};

endmodule

// ===== hdl/i2cms_checker.sv =====
// Port-level checks for the I2C master transaction sequencer, bound to the top.
// Uses i2cms_pkg.
module i2cms_checker
    import i2cms_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_done_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[17] |-> m_axis_tuser == A_STOP)
        else $error("done without stop");

    a_stop_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == A_STOP |-> m_axis_tdata[17]
            && (m_axis_tdata[18] != m_axis_tdata[19]))
        else $error("stop without exactly one of success and disable");

    a_tx_only_on_send: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != A_SEND |-> m_axis_tdata[7:0] == 8'd0)
        else $error("tx byte outside send");

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_i2cms_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
